@@ sv/dzh_pkg.sv @@
package dzh_pkg;

   typedef enum logic [3:0] {
      P_IDLE    = 4'd0,
      P_FIXED   = 4'd1,
      P_XLEN    = 4'd2,
      P_SI1     = 4'd3,
      P_SI2     = 4'd4,
      P_SUBLEN  = 4'd5,
      P_VER     = 4'd6,
      P_CLEN    = 4'd7,
      P_CCNT    = 4'd8,
      P_CHUNKS  = 4'd9,
      P_XSKIP   = 4'd10,
      P_NAME    = 4'd11,
      P_COMMENT = 4'd12,
      P_HCRC    = 4'd13
   } phase_type;

   localparam logic [7:0] MAGIC1   = 8'h1f;
   localparam logic [7:0] MAGIC2   = 8'h8b;
   localparam logic [7:0] SI_R     = 8'h52;
   localparam logic [7:0] SI_A     = 8'h41;
   localparam int         FL_HCRC  = 1;
   localparam int         FL_EXTRA = 2;
   localparam int         FL_NAME  = 3;
   localparam int         FL_CMT   = 4;

   localparam logic [1:0] ST_TEXT  = 2'd0;
   localparam logic [1:0] ST_GZIP  = 2'd1;
   localparam logic [1:0] ST_DZ    = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   localparam logic KIND_CHUNK   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic        record_kind;
      logic [15:0] chunk_index;
      logic [15:0] chunk_size;
      logic [31:0] chunk_offset;
      logic [7:0]  method;
      logic [7:0]  flag_bits;
      logic [31:0] mod_time;
      logic [7:0]  extra_flag_bits;
      logic [7:0]  os_code;
      logic [15:0] uncompressed_chunk_len;
      logic [1:0]  status;
      logic [31:0] data_start;
   } rec_type;

endpackage

@@ sv/dzh_if.sv @@
interface dzh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   modport source (output valid, data_byte, first_byte, input ready);
   modport sink (input valid, data_byte, first_byte, output ready);
endinterface

interface dzh_rsp_if;
   import dzh_pkg::*;
   logic    valid;
   logic    ready;
   rec_type rec;
   modport source (output valid, rec, input ready);
   modport sink (input valid, rec, output ready);
endinterface

@@ sv/dzh_parser.sv @@
// Front: parses one byte a cycle while step is high, makes up to two records.
module dzh_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       b,
   input  logic             first,
   output logic [1:0]       n_rec,
   output dzh_pkg::rec_type rec0,
   output dzh_pkg::rec_type rec1
);
   import dzh_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        fbc_ff, fbc_in;
   logic [7:0]  low_ff, low_in, flags_ff, flags_in, method_ff, method_in;
   logic [31:0] mtime_ff, mtime_in;
   logic [7:0]  xfl_ff, xfl_in, os_ff, os_in;
   logic [15:0] xlen_ff, xlen_in, xcons_ff, xcons_in;
   logic [15:0] clen_ff, clen_in, ctot_ff, ctot_in, ccnt_ff, ccnt_in;
   logic [31:0] roff_ff, roff_in, hb_ff, hb_in;
   logic        dz_ff, dz_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE; fbc_ff <= 1'b0; low_ff <= '0; flags_ff <= '0;
         method_ff <= '0; mtime_ff <= '0; xfl_ff <= '0; os_ff <= '0;
         xlen_ff <= '0; xcons_ff <= '0; clen_ff <= '0; ctot_ff <= '0;
         ccnt_ff <= '0; roff_ff <= '0; hb_ff <= '0; dz_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; fbc_ff <= fbc_in; low_ff <= low_in;
         flags_ff <= flags_in; method_ff <= method_in; mtime_ff <= mtime_in;
         xfl_ff <= xfl_in; os_ff <= os_in; xlen_ff <= xlen_in;
         xcons_ff <= xcons_in; clen_ff <= clen_in; ctot_ff <= ctot_in;
         ccnt_ff <= ccnt_in; roff_ff <= roff_in; hb_ff <= hb_in; dz_ff <= dz_in;
      end
   end

   logic [15:0] v16, xc_bump;
   logic [31:0] idx;
   logic [1:0]  sum_st;
   logic [31:0] sum_start;
   logic        sum_a, sum_b, sum_hold;

   always_comb begin
      phase_in = phase_ff; fbc_in = fbc_ff; low_in = low_ff;
      flags_in = flags_ff; method_in = method_ff; mtime_in = mtime_ff;
      xfl_in = xfl_ff; os_in = os_ff; xlen_in = xlen_ff; xcons_in = xcons_ff;
      clen_in = clen_ff; ctot_in = ctot_ff; ccnt_in = ccnt_ff;
      roff_in = roff_ff; hb_in = hb_ff; dz_in = dz_ff;
      v16 = {b, low_ff};
      idx = hb_ff;
      xc_bump = (xcons_ff != 16'hFFFF) ? xcons_ff + 16'd1 : xcons_ff;
      n_rec = 2'd0;
      rec0 = '0; rec1 = '0;
      // summary requests: sum_a in rec0, sum_b in rec1
      sum_a = 1'b0; sum_b = 1'b0; sum_hold = 1'b0;
      sum_st = ST_GZIP; sum_start = hb_ff;
      if (first) begin
         phase_in = P_FIXED; fbc_in = 1'b0; low_in = b; flags_in = '0;
         method_in = '0; mtime_in = '0; xfl_in = '0; os_in = '0;
         xlen_in = '0; xcons_in = '0; clen_in = '0; ctot_in = '0;
         ccnt_in = '0; roff_in = '0; hb_in = 32'd1; dz_in = 1'b0;
      end else if (phase_ff != P_IDLE) begin
         if (hb_ff != 32'hFFFFFFFF) hb_in = hb_ff + 32'd1;
         sum_start = hb_in;
         case (phase_ff)
            P_FIXED: begin
               if (idx == 32'd1) begin
                  if (low_ff != MAGIC1 || b != MAGIC2) begin
                     sum_a = 1'b1; sum_st = ST_TEXT; sum_start = '0;
                  end
               end else if (idx == 32'd2) method_in = b;
               else if (idx == 32'd3) flags_in = b;
               else if (idx inside {[32'd4:32'd7]})
                  mtime_in = mtime_ff | ({24'd0, b} << {idx[1:0], 3'd0});
               else if (idx == 32'd8) xfl_in = b;
               else begin
                  os_in = b; fbc_in = 1'b0;
                  if (flags_ff[FL_EXTRA]) phase_in = P_XLEN;
                  else sum_a = 1'b1;
               end
            end
            P_XLEN: begin
               fbc_in = ~fbc_ff;
               if (!fbc_ff) low_in = b;
               else begin
                  xlen_in = v16;
                  if (v16 == 16'd0) sum_a = 1'b1;
                  else phase_in = P_SI1;
               end
            end
            P_SI1: begin
               low_in = b; xcons_in = xc_bump;
               if (xc_bump >= xlen_ff) sum_a = 1'b1;
               else phase_in = P_SI2;
            end
            P_SI2: begin
               xcons_in = xc_bump;
               if (low_ff == SI_R && b == SI_A) begin
                  fbc_in = 1'b0; phase_in = P_SUBLEN;
               end else if (xc_bump >= xlen_ff) sum_a = 1'b1;
               else phase_in = P_XSKIP;
            end
            P_SUBLEN, P_VER, P_CLEN, P_CCNT: begin
               xcons_in = xc_bump; fbc_in = ~fbc_ff;
               if (!fbc_ff) low_in = b;
               else begin
                  case (phase_ff)
                     P_SUBLEN: phase_in = P_VER;
                     P_VER:    phase_in = P_CLEN;
                     P_CLEN: begin clen_in = v16; phase_in = P_CCNT; end
                     default: begin
                        ctot_in = v16;
                        if (v16 == 16'd0) begin
                           sum_hold = 1'b1; sum_a = 1'b1; sum_st = ST_ZERO;
                        end else begin
                           ccnt_in = '0; roff_in = '0; phase_in = P_CHUNKS;
                        end
                     end
                  endcase
               end
            end
            P_CHUNKS: begin
               xcons_in = xc_bump; fbc_in = ~fbc_ff;
               if (!fbc_ff) low_in = b;
               else begin
                  n_rec = 2'd1;
                  rec0.record_kind = KIND_CHUNK;
                  rec0.chunk_index = ccnt_ff;
                  rec0.chunk_size = v16;
                  rec0.chunk_offset = roff_ff;
                  roff_in = roff_ff + {16'd0, v16};
                  ccnt_in = ccnt_ff + 16'd1;
                  if (ccnt_in == ctot_ff) begin
                     dz_in = 1'b1;
                     if (xc_bump >= xlen_ff) sum_b = 1'b1;
                     else phase_in = P_XSKIP;
                  end
               end
            end
            P_XSKIP: begin
               xcons_in = xc_bump;
               if (xc_bump >= xlen_ff) sum_a = 1'b1;
            end
            P_NAME:    if (b == 8'd0) sum_a = 1'b1;
            P_COMMENT: if (b == 8'd0) sum_a = 1'b1;
            P_HCRC: begin
               fbc_in = ~fbc_ff;
               if (!fbc_ff) low_in = b;
               else sum_a = 1'b1;
            end
            default: phase_in = P_IDLE;
         endcase
         // optional sections after the current stage
         if ((sum_a || sum_b) && !sum_hold && sum_st != ST_TEXT) begin
            if ((phase_ff <= P_XSKIP) && flags_in[FL_NAME]) begin
               phase_in = P_NAME; sum_a = 1'b0; sum_b = 1'b0;
            end else if (phase_ff <= P_NAME && flags_in[FL_CMT]) begin
               phase_in = P_COMMENT; sum_a = 1'b0; sum_b = 1'b0;
            end else if (phase_ff <= P_COMMENT && flags_in[FL_HCRC]) begin
               phase_in = P_HCRC; fbc_in = 1'b0; sum_a = 1'b0; sum_b = 1'b0;
            end else sum_st = dz_in ? ST_DZ : ST_GZIP;
         end
         if (sum_a || sum_b) begin
            phase_in = P_IDLE;
            if (sum_b) begin
               n_rec = 2'd2;
               rec1.record_kind = KIND_SUMMARY;
            end else begin
               n_rec = 2'd1;
               rec0.record_kind = KIND_SUMMARY;
            end
         end
      end
      if (sum_a) begin
         rec0.chunk_index = ctot_in; rec0.chunk_size = '0;
         rec0.chunk_offset = roff_in; rec0.method = method_in;
         rec0.flag_bits = flags_in; rec0.mod_time = mtime_in;
         rec0.extra_flag_bits = xfl_in; rec0.os_code = os_in;
         rec0.uncompressed_chunk_len = clen_in; rec0.status = sum_st;
         rec0.data_start = sum_start;
      end
      if (sum_b) begin
         rec1.chunk_index = ctot_in; rec1.chunk_size = '0;
         rec1.chunk_offset = roff_in; rec1.method = method_in;
         rec1.flag_bits = flags_in; rec1.mod_time = mtime_in;
         rec1.extra_flag_bits = xfl_in; rec1.os_code = os_in;
         rec1.uncompressed_chunk_len = clen_in; rec1.status = sum_st;
         rec1.data_start = sum_start;
      end
   end
endmodule

@@ sv/dzh_queue.sv @@
// Back: record queue, takes up to two records a cycle, delivers one while rsp.ready is high.
module dzh_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       n_push,
   input  dzh_pkg::rec_type rec0,
   input  dzh_pkg::rec_type rec1,
   output logic             room,
   dzh_rsp_if.source        rsp
);
   import dzh_pkg::*;

   localparam int DEPTH = 4;
   rec_type     mem_ff [DEPTH];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;
   logic        pop;

   assign pop = rsp.valid && rsp.ready;
   assign rsp.valid = cnt_ff != 3'd0;
   assign rsp.rec = mem_ff[rp_ff];
   assign room = cnt_ff <= 3'd2;

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) mem_ff[wp_ff] <= rec0;
      if (n_push == 2'd2) mem_ff[wp_ff + 2'd1] <= rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + n_push;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {1'b0, n_push} - {2'd0, pop};
      end
   end
endmodule

@@ sv/dictzip_header_parser.sv @@
// A record is queued as its closing byte is accepted; output is registered.
// Throughput: one request per cycle while ready is high; up to two records
// per request feed a four-entry record queue, ready drops when fewer than
// two slots are free. Reset: synchronous, active high; parser goes idle
// awaiting a start byte, queue empties.
module dictzip_header_parser (
   input logic      clock,
   input logic      reset,
   dzh_req_if.sink  req,
   dzh_rsp_if.source rsp
);
   import dzh_pkg::*;

   logic       room, step;
   logic [1:0] n_rec, n_push;
   rec_type    rec0, rec1;

   // accept only when a worst case pair of records fits
   assign req.ready = room;
   assign step = req.valid && req.ready;
   assign n_push = step ? n_rec : 2'd0;

   dzh_parser u_parser (
      .clock(clock), .reset(reset), .step(step), .b(req.data_byte),
      .first(req.first_byte), .n_rec(n_rec), .rec0(rec0), .rec1(rec1)
   );

   dzh_queue u_queue (
      .clock(clock), .reset(reset), .n_push(n_push), .rec0(rec0),
      .rec1(rec1), .room(room), .rsp(rsp)
   );

   // a second record is always the summary behind a chunk entry
   a_pair: assert property (@(posedge clock) disable iff (reset)
      n_push == 2'd2 |-> rec0.record_kind == KIND_CHUNK &&
                         rec1.record_kind == KIND_SUMMARY)
      else $error("bad record pair");

   // no records from a start byte
   a_start: assert property (@(posedge clock) disable iff (reset)
      step && req.first_byte |-> n_rec == 2'd0)
      else $error("record on start byte");

   // after a push the output is valid in the next cycle
   a_room: assert property (@(posedge clock) disable iff (reset)
      n_push != 2'd0 |=> rsp.valid)
      else $error("push without output");
endmodule
